// ===== hw/rtl/brs_pkg.sv =====
// Shared types, constants and the preset table of the beat repeat slicer.
package brs_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int RING_DEPTH    = 131072;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 4;

    localparam int TYPE_BITS     = 4;
    localparam int DEPTH_BITS    = 16;
    localparam int WNS_BITS      = 24;
    localparam int MIX_FRAC      = 15;

    localparam logic [DEPTH_BITS-1:0] FULL_DEPTH = 16'd32768;
    localparam logic [TYPE_BITS-1:0]  TYPE_FIRST = 4'd1;
    localparam logic [TYPE_BITS-1:0]  TYPE_LAST  = 4'd10;

    localparam logic [TYPE_BITS-1:0]  EFFECT_TYPE_RESET = 4'd0;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET       = 16'd0;
    localparam logic [WNS_BITS-1:0]   WHOLE_NOTE_RESET  = 24'd88200;

    typedef enum logic [1:0] {
        REG_EFFECT_TYPE = 2'd0,
        REG_DEPTH       = 2'd1,
        REG_WHOLE_NOTE  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        PRIM_REPEAT   = 2'd0,
        PRIM_REVERSE  = 2'd1,
        PRIM_GATE     = 2'd2,
        PRIM_DECIMATE = 2'd3
    } t_prim;

    // subdivision and stride as shift amounts (sub = 1 << sub_shift)
    typedef struct packed {
        t_prim      prim;
        logic [2:0] sub_shift;
        logic [2:0] stride_shift;
        logic       backward;
    } t_preset;

    localparam int NUM_PRESETS = 10;

    localparam t_preset PRESETS [NUM_PRESETS] = '{
        '{PRIM_REPEAT,   3'd3, 3'd0, 1'b0},
        '{PRIM_REPEAT,   3'd4, 3'd0, 1'b0},
        '{PRIM_REPEAT,   3'd5, 3'd0, 1'b0},
        '{PRIM_REVERSE,  3'd3, 3'd0, 1'b0},
        '{PRIM_REVERSE,  3'd4, 3'd0, 1'b0},
        '{PRIM_GATE,     3'd4, 3'd0, 1'b0},
        '{PRIM_GATE,     3'd5, 3'd0, 1'b0},
        '{PRIM_DECIMATE, 3'd4, 3'd2, 1'b0},
        '{PRIM_DECIMATE, 3'd4, 3'd4, 1'b0},
        '{PRIM_REPEAT,   3'd5, 3'd0, 1'b1}
    };

    function automatic t_preset preset_lookup(input logic [TYPE_BITS-1:0] code);
        logic [TYPE_BITS-1:0] idx;
        idx = code - TYPE_FIRST;
        if (code >= TYPE_FIRST && code <= TYPE_LAST) begin
            return PRESETS[idx];
        end
        return PRESETS[0];
    endfunction

    typedef struct packed {
        logic [TYPE_BITS-1:0]  effect_type;
        logic [DEPTH_BITS-1:0] depth;
        logic [WNS_BITS-1:0]   whole_note;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic ring_we;
        logic latch_len;
        logic cap_setup;
        logic cap_step;
        logic slice_rd;
        logic mul;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic capture_needed;
        logic cap_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/brs_if.sv =====
// Request channel interfaces for input samples and mixed output samples.
interface brs_in_if #(
    parameter int W = brs_pkg::SAMPLE_BITS
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_left;
    logic signed [W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface brs_out_if #(
    parameter int W = brs_pkg::SAMPLE_BITS
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_left;
    logic signed [W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== hw/rtl/brs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module brs_ram #(
    parameter int WIDTH = 2 * brs_pkg::SAMPLE_BITS,
    parameter int DEPTH = brs_pkg::RING_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/brs_cfg.sv =====
// APB-style register file for effect type, depth and whole-note length.
module brs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brs_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [brs_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output brs_pkg::t_cfg                       o_cfg
);
    brs_pkg::t_cfg r_cfg;
    logic [1:0]    idx;
    logic          wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effect_type <= brs_pkg::EFFECT_TYPE_RESET;
            r_cfg.depth       <= brs_pkg::DEPTH_RESET;
            r_cfg.whole_note  <= brs_pkg::WHOLE_NOTE_RESET;
        end else if (wr_en) begin
            case (idx)
                brs_pkg::REG_EFFECT_TYPE: begin
                    r_cfg.effect_type <= pwdata[brs_pkg::TYPE_BITS-1:0];
                end
                brs_pkg::REG_DEPTH: begin
                    r_cfg.depth <= pwdata[brs_pkg::DEPTH_BITS-1:0];
                end
                brs_pkg::REG_WHOLE_NOTE: begin
                    r_cfg.whole_note <= pwdata[brs_pkg::WNS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            brs_pkg::REG_EFFECT_TYPE: begin
                prdata = brs_pkg::CFG_DATA_BITS'(r_cfg.effect_type);
            end
            brs_pkg::REG_DEPTH: begin
                prdata = brs_pkg::CFG_DATA_BITS'(r_cfg.depth);
            end
            brs_pkg::REG_WHOLE_NOTE: begin
                prdata = brs_pkg::CFG_DATA_BITS'(r_cfg.whole_note);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hw/rtl/brs_ctrl.sv =====
// Sequencer: per-sample steps, slice copy loop and output handoff.
module brs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  brs_pkg::t_dp_status  i_status,
    output brs_pkg::t_dp_cmd     o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_WRITE     = 8'b0000_0010,
        S_CAP_SETUP = 8'b0000_0100,
        S_CAP       = 8'b0000_1000,
        S_DRAIN     = 8'b0001_0000,
        S_READ      = 8'b0010_0000,
        S_MUL       = 8'b0100_0000,
        S_FIN       = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // a new request may come in while the finished sample loads the output
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_FIN) && i_status.out_free);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.load_in = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.ring_we = 1'b1;
                if (i_status.capture_needed) begin
                    o_cmd.latch_len = 1'b1;
                    n_state         = S_CAP_SETUP;
                end else begin
                    o_cmd.slice_rd = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_CAP_SETUP: begin
                o_cmd.cap_setup = 1'b1;
                n_state         = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_step = 1'b1;
                if (i_status.cap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last slice write lands here
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.slice_rd = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = accept ? S_WRITE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hw/rtl/brs_dp.sv =====
// Datapath: ring and slice stores, slice addressing, wet/dry mix and output register.
module brs_dp #(
    parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS,
    parameter int RING_DEPTH  = brs_pkg::RING_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brs_pkg::t_cfg                 i_cfg,
    input  brs_pkg::t_dp_cmd              i_cmd,
    output brs_pkg::t_dp_status           o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right
);
    localparam int W   = SAMPLE_BITS;
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int DW  = 2 * W;
    localparam int PW  = W + brs_pkg::DEPTH_BITS + 2;
    localparam int NLW = brs_pkg::WNS_BITS + 1;

    localparam logic [AW-1:0]         LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [NLW-1:0]        LEN_MAX   = NLW'(RING_DEPTH - 1);
    localparam longint                MAX_L     = (longint'(1) << (W - 1)) - 1;
    localparam logic signed [PW-1:0]  MAXV      = PW'(MAX_L);
    localparam logic signed [PW-1:0]  MINV      = PW'(-MAX_L - 1);
    localparam logic signed [PW-1:0]  HALF      = PW'(longint'(1) << (brs_pkg::MIX_FRAC - 1));

    function automatic logic signed [W-1:0] mix_round(input logic signed [PW-1:0] prod,
                                                       input logic signed [W-1:0]  dry);
        logic signed [PW-1:0] sum;
        sum = ((prod + HALF) >>> brs_pkg::MIX_FRAC) + signed'({{(PW-W){dry[W-1]}}, dry});
        if (sum > MAXV) begin
            sum = MAXV;
        end else if (sum < MINV) begin
            sum = MINV;
        end
        return sum[W-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    // payload
    logic signed [W-1:0]  r_dry_l;
    logic signed [W-1:0]  r_dry_r;
    logic signed [PW-1:0] r_prod_l;
    logic signed [PW-1:0] r_prod_r;
    logic signed [W-1:0]  r_out_l;
    logic signed [W-1:0]  r_out_r;
    logic [AW-1:0]        r_cap_addr;
    logic                 r_cap_mask;
    logic                 r_on;

    // control
    logic [AW-1:0]        r_wp;
    logic                 r_wrapped;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_len;
    logic                 r_prev;
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        r_cnt;
    logic                 r_cap_we;
    logic                 r_out_valid;

    brs_pkg::t_preset                 preset;
    logic                             active;
    logic [brs_pkg::DEPTH_BITS-1:0]   d_clamp;
    logic [NLW-1:0]                   nl_sum;
    logic [NLW-1:0]                   nl_raw;
    logic [AW-1:0]                    len_new;
    logic [AW:0]                      src_diff;
    logic [AW-1:0]                    src_start;
    logic [AW-1:0]                    rev_off;
    logic [AW-1:0]                    dec_mask;
    logic [AW-1:0]                    off_raw;
    logic [AW-1:0]                    off;
    logic                             on;
    logic                             ring_valid;
    logic [DW-1:0]                    ring_q;
    logic [DW-1:0]                    slice_q;
    logic [DW-1:0]                    slice_wdata;
    logic signed [W-1:0]              wet_l;
    logic signed [W-1:0]              wet_r;
    logic signed [W:0]                diff_l;
    logic signed [W:0]                diff_r;
    logic signed [brs_pkg::DEPTH_BITS:0] coef;
    logic [AW-1:0]                    pos_next;

    always_comb begin
        preset  = brs_pkg::preset_lookup(i_cfg.effect_type);
        active  = (i_cfg.effect_type inside {[brs_pkg::TYPE_FIRST:brs_pkg::TYPE_LAST]})
                  && (i_cfg.depth != '0);
        d_clamp = (i_cfg.depth > brs_pkg::FULL_DEPTH) ? brs_pkg::FULL_DEPTH : i_cfg.depth;

        // rounded whole note / subdivision, clamped to 1 .. RING_DEPTH-1
        nl_sum = {1'b0, i_cfg.whole_note} + (NLW'(1) << (preset.sub_shift - 3'd1));
        nl_raw = nl_sum >> preset.sub_shift;
        if (nl_raw > LEN_MAX) begin
            len_new = LAST_ADDR;
        end else if (nl_raw == '0) begin
            len_new = AW'(1);
        end else begin
            len_new = nl_raw[AW-1:0];
        end

        // oldest sample of the newest slice, modulo ring depth
        src_diff = {1'b0, r_wp} + (AW+1)'(1) - {1'b0, r_len};
        if (src_diff[AW]) begin
            src_diff = src_diff + (AW+1)'(RING_DEPTH);
        end
        src_start = src_diff[AW-1:0];

        // ring entries not yet written since reset read as zero
        ring_valid = r_wrapped || (r_src <= r_wp);

        rev_off  = (r_pos < r_len) ? r_len - AW'(1) - r_pos : '0;
        dec_mask = {AW{1'b1}} << preset.stride_shift;
        on       = 1'b1;
        case (preset.prim)
            brs_pkg::PRIM_REVERSE: begin
                off_raw = rev_off;
            end
            brs_pkg::PRIM_GATE: begin
                off_raw = r_pos;
                on      = r_pos < (r_len >> 1);
            end
            brs_pkg::PRIM_DECIMATE: begin
                off_raw = r_pos & dec_mask;
            end
            default: begin
                off_raw = preset.backward ? rev_off : r_pos;
            end
        endcase
        off = (off_raw >= r_len) ? r_len - AW'(1) : off_raw;

        wet_l  = r_on ? slice_q[DW-1:W] : '0;
        wet_r  = r_on ? slice_q[W-1:0]  : '0;
        diff_l = {wet_l[W-1], wet_l} - {r_dry_l[W-1], r_dry_l};
        diff_r = {wet_r[W-1], wet_r} - {r_dry_r[W-1], r_dry_r};
        coef   = {1'b0, d_clamp};

        pos_next = (r_pos + AW'(1) >= r_len) ? '0 : r_pos + AW'(1);

        slice_wdata = r_cap_mask ? ring_q : '0;
    end

    brs_ram #(
        .WIDTH (DW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring_we),
        .i_waddr (r_wp),
        .i_wdata ({r_dry_l, r_dry_r}),
        .i_re    (i_cmd.cap_step),
        .i_raddr (r_src),
        .o_rdata (ring_q)
    );

    brs_ram #(
        .WIDTH (DW),
        .DEPTH (RING_DEPTH)
    ) u_slice (
        .i_clk   (i_clk),
        .i_we    (r_cap_we),
        .i_waddr (r_cap_addr),
        .i_wdata (slice_wdata),
        .i_re    (i_cmd.slice_rd),
        .i_raddr (off),
        .o_rdata (slice_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dry_l <= i_sample_left;
            r_dry_r <= i_sample_right;
        end
        if (i_cmd.cap_step) begin
            r_cap_addr <= r_cnt;
            r_cap_mask <= ring_valid;
        end
        if (i_cmd.slice_rd) begin
            r_on <= on;
        end
        if (i_cmd.mul) begin
            r_prod_l <= diff_l * coef;
            r_prod_r <= diff_r * coef;
        end
        if (i_cmd.fin) begin
            r_out_l <= active ? mix_round(r_prod_l, r_dry_l) : r_dry_l;
            r_out_r <= active ? mix_round(r_prod_r, r_dry_r) : r_dry_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_pos       <= '0;
            r_len       <= AW'(1);
            r_prev      <= 1'b0;
            r_src       <= '0;
            r_cnt       <= '0;
            r_cap_we    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_we <= i_cmd.cap_step;
            if (i_cmd.latch_len) begin
                r_len <= len_new;
                r_pos <= '0;
            end
            if (i_cmd.cap_setup) begin
                r_src <= src_start;
                r_cnt <= '0;
            end
            if (i_cmd.cap_step) begin
                r_src <= addr_inc(r_src);
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.fin) begin
                if (active) begin
                    r_pos <= pos_next;
                end
                r_prev <= active;
                r_wp   <= addr_inc(r_wp);
                if (r_wp == LAST_ADDR) begin
                    r_wrapped <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.capture_needed = active && !r_prev;
    assign o_status.cap_last       = (r_cnt == r_len - AW'(1));
    assign o_status.out_free       = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
endmodule

// ===== hw/rtl/beat_repeat_slicer_top.sv =====
// Top level of the beat repeat slicer: registers, sequencer and datapath.
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      sample_left, sample_right
//  o_out     out  valid / ready      out_left, out_right
//  apb       in   psel/penable/pwrite  paddr, pwdata -> prdata (pready tied high)
//
// A sample passes from its request to its result through accept, ring write plus
// slice read, multiply, round/saturate into the output register. The next request
// is taken in that last step, so samples follow back to back.
// The first active sample adds a slice copy through setup, copy and drain steps, one ring
// read and one slice write per cycle. Reset needs no clearing pass: a wrap flag
// marks unwritten ring entries, which copy as zero. With the output register
// full and not taken, the sequencer holds in its last step and takes no request.
module beat_repeat_slicer_top #(
    parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS,
    parameter int RING_DEPTH  = brs_pkg::RING_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    brs_in_if.sink                            i_in,
    brs_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brs_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [brs_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    brs_pkg::t_cfg       cfg;
    brs_pkg::t_dp_cmd    cmd;
    brs_pkg::t_dp_status status;
    logic                in_ready;

    brs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    brs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    brs_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample_left  (i_in.sample_left),
        .i_sample_right (i_in.sample_right),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_left     (o_out.out_left),
        .o_out_right    (o_out.out_right)
    );

    assign i_in.ready = in_ready;
endmodule
